[src/rvu_pkg.sv]
`timescale 1ns / 1ps
package rvu_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int FRACTION_BITS_DEF   = 14;

    // Working width for rounding and saturation of intermediates
    localparam int WIDE_W = 72;

    // Result outcome codes
    localparam logic [1:0] OUT_REFRACT    = 2'd0;
    localparam logic [1:0] OUT_TIR        = 2'd1;
    localparam logic [1:0] OUT_ZERO_INDEX = 2'd2;

    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [31:0]       t_s32;

    // Round a product with f fraction bits, half up, then floor
    function automatic t_wide round_shr(t_wide p, int f);
        t_wide half;
        half = t_wide'(1) <<< (f - 1);
        return (p + half) >>> f;
    endfunction

    // Saturate to the signed 32-bit range
    function automatic t_s32 sat32(t_wide v);
        t_s32 res;
        if (v > t_wide'(64'sd2147483647)) begin
            res = 32'sh7fff_ffff;
        end else if (v < -t_wide'(64'sd2147483648)) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

[src/rvu_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage.
module rvu_div #(
    parameter int DN = 31,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic [DN-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic [DN-1:0] o_quotient
);

    logic [DW-1:0] r_rem [0:DN-1];
    logic [DW-1:0] r_den [0:DN-1];
    logic [DN-1:0] r_quo [0:DN-1];
    logic [DN-1:0] r_dvd [0:DN-1];

    genvar k;
    generate
        for (k = 0; k < DN; k++) begin : g_stage
            logic [DW-1:0] rem_prev;
            logic [DW-1:0] den_prev;
            logic [DN-1:0] quo_prev;
            logic [DN-1:0] dvd_prev;
            logic [DW:0]   rem_in;
            logic [DW:0]   rem_sub;

            if (k == 0) begin : g_first
                assign rem_prev = '0;
                assign den_prev = i_divisor;
                assign quo_prev = '0;
                assign dvd_prev = i_dividend;
            end else begin : g_next
                assign rem_prev = r_rem[k-1];
                assign den_prev = r_den[k-1];
                assign quo_prev = r_quo[k-1];
                assign dvd_prev = r_dvd[k-1];
            end

            // Bring down the next dividend bit and try the subtract
            assign rem_in  = {rem_prev, dvd_prev[DN-1]};
            assign rem_sub = rem_in - {1'b0, den_prev};

            always_ff @(posedge i_clk) begin
                if (rem_in >= {1'b0, den_prev}) begin
                    r_rem[k] <= rem_sub[DW-1:0];
                    r_quo[k] <= {quo_prev[DN-2:0], 1'b1};
                end else begin
                    r_rem[k] <= rem_in[DW-1:0];
                    r_quo[k] <= {quo_prev[DN-2:0], 1'b0};
                end
                r_dvd[k] <= {dvd_prev[DN-2:0], 1'b0};
                r_den[k] <= den_prev;
            end
        end
    endgenerate

    assign o_quotient = r_quo[DN-1];

endmodule

[src/rvu_sqrt.sv]
`timescale 1ns / 1ps
// Digit-by-digit integer square root, one root bit per stage.
module rvu_sqrt #(
    parameter int RB = 15
) (
    input  logic            i_clk,
    input  logic [2*RB-1:0] i_radicand,
    output logic [RB-1:0]   o_root
);

    logic [RB+1:0]   r_rem  [0:RB-1];
    logic [RB-1:0]   r_root [0:RB-1];
    logic [2*RB-1:0] r_rad  [0:RB-1];

    genvar k;
    generate
        for (k = 0; k < RB; k++) begin : g_stage
            logic [RB+1:0]   rem_prev;
            logic [RB-1:0]   root_prev;
            logic [2*RB-1:0] rad_prev;
            logic [RB+3:0]   rem_in;
            logic [RB+3:0]   trial;
            logic [RB+3:0]   rem_sub;

            if (k == 0) begin : g_first
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign rad_prev  = i_radicand;
            end else begin : g_next
                assign rem_prev  = r_rem[k-1];
                assign root_prev = r_root[k-1];
                assign rad_prev  = r_rad[k-1];
            end

            // Bring down two radicand bits, try root*4+1
            assign rem_in  = {rem_prev, rad_prev[2*RB-1 -: 2]};
            assign trial   = (RB+4)'({root_prev, 2'b01});
            assign rem_sub = rem_in - trial;

            always_ff @(posedge i_clk) begin
                if (rem_in >= trial) begin
                    r_rem[k]  <= rem_sub[RB+1:0];
                    r_root[k] <= {root_prev[RB-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= rem_in[RB+1:0];
                    r_root[k] <= {root_prev[RB-2:0], 1'b0};
                end
                r_rad[k] <= {rad_prev[2*RB-3:0], 2'b00};
            end
        end
    endgenerate

    assign o_root = r_root[RB-1];

endmodule

[src/refraction_vector_unit.sv]
`timescale 1ns / 1ps
// Refraction vector unit: forms T = S - c*N from a unit incident vector L,
// a unit normal N and the two refractive indices, flagging total internal
// reflection and a zero index. Fully pipelined: one item may be started in
// every cycle and busy never rises. Each result appears on the o_ ports for
// one cycle with o_valid high. The latency is set by the bit-per-stage index
// divider (W+F+1 stages) and square root (F+1 stages). The receiver cannot
// stall, so results must be taken when shown.
module refraction_vector_unit
    import rvu_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
    parameter int FRACTION_BITS   = FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COMPONENT_WIDTH-1:0] i_incident_x,
    input  logic signed [COMPONENT_WIDTH-1:0] i_incident_y,
    input  logic signed [COMPONENT_WIDTH-1:0] i_incident_z,
    input  logic signed [COMPONENT_WIDTH-1:0] i_normal_x,
    input  logic signed [COMPONENT_WIDTH-1:0] i_normal_y,
    input  logic signed [COMPONENT_WIDTH-1:0] i_normal_z,
    input  logic        [COMPONENT_WIDTH-1:0] i_index_front,
    input  logic        [COMPONENT_WIDTH-1:0] i_index_back,
    output logic                              o_valid,
    output logic signed [COMPONENT_WIDTH-1:0] o_refracted_x,
    output logic signed [COMPONENT_WIDTH-1:0] o_refracted_y,
    output logic signed [COMPONENT_WIDTH-1:0] o_refracted_z,
    output logic        [1:0]                 o_outcome
);

    localparam int W    = COMPONENT_WIDTH;
    localparam int F    = FRACTION_BITS;
    localparam int DN   = W + F + 1;
    localparam int RB   = F + 1;
    localparam int SBW  = 3 * W + 2;
    localparam int TGW  = 3 * 32;
    localparam int SSW  = TGW + 1 + SBW;
    localparam int IA   = 2 + DN;
    localparam int IS   = IA + 4;
    localparam int OI   = IS + RB + 2;
    localparam int LAT  = OI + 1;

    localparam t_wide ONE_W  = t_wide'(1) <<< F;
    localparam t_wide SMAX_W = (t_wide'(1) <<< (W - 1)) - t_wide'(1);
    localparam t_wide SMIN_W = -SMAX_W - t_wide'(1);

    logic           accept;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Advance the valid bits with the data
    assign n_vld = {r_vld[LAT-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Stage 0: capture the transfer
    logic signed [W-1:0] r0_l [0:2];
    logic signed [W-1:0] r0_n [0:2];
    logic        [W-1:0] r0_nf;
    logic        [W-1:0] r0_nb;

    always_ff @(posedge i_clk) begin
        r0_l[0] <= i_incident_x;
        r0_l[1] <= i_incident_y;
        r0_l[2] <= i_incident_z;
        r0_n[0] <= i_normal_x;
        r0_n[1] <= i_normal_y;
        r0_n[2] <= i_normal_z;
        r0_nf   <= i_index_front;
        r0_nb   <= i_index_back;
    end

    // Stage 1: N.L lane products
    logic signed [2*W-1:0] r1_p [0:2];
    logic signed [W-1:0]   r1_l [0:2];
    logic signed [W-1:0]   r1_n [0:2];
    logic        [W-1:0]   r1_nf;
    logic        [W-1:0]   r1_nb;
    logic                  r1_zero;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_p[i] <= r0_n[i] * r0_l[i];
            r1_l[i] <= r0_l[i];
            r1_n[i] <= r0_n[i];
        end
        r1_nf   <= r0_nf;
        r1_nb   <= r0_nb;
        r1_zero <= (r0_nf == '0) || (r0_nb == '0);
    end

    // Stage 2: round, sum and saturate the dot product, pick the index ratio
    t_wide dot_sum;
    t_s32  dot_sat;

    assign dot_sum = round_shr(t_wide'(r1_p[0]), F) + round_shr(t_wide'(r1_p[1]), F)
                   + round_shr(t_wide'(r1_p[2]), F);
    assign dot_sat = sat32(dot_sum);

    t_s32                r2_d;
    logic        [W-1:0] r2_num;
    logic        [W-1:0] r2_den;
    logic signed [W-1:0] r2_l [0:2];
    logic signed [W-1:0] r2_n [0:2];
    logic                r2_zero;

    always_ff @(posedge i_clk) begin
        r2_d <= dot_sat;
        if (dot_sat > 32'sd0) begin
            r2_num <= r1_nf;
            r2_den <= r1_nb;
        end else begin
            r2_num <= r1_nb;
            r2_den <= r1_nf;
        end
        for (int i = 0; i < 3; i++) begin
            r2_l[i] <= r1_l[i];
            r2_n[i] <= r1_n[i];
        end
        r2_zero <= r1_zero;
    end

    // Index ratio divider, stages 3 .. IA
    logic [DN-1:0] div_dvd;
    logic [DN-1:0] div_quo;

    assign div_dvd = (DN'(r2_num) << F) + DN'(r2_den >> 1);

    rvu_div #(
        .DN (DN),
        .DW (W)
    ) u_div (
        .i_clk      (i_clk),
        .i_dividend (div_dvd),
        .i_divisor  (r2_den),
        .o_quotient (div_quo)
    );

    // Carry normal, side and zero flag alongside the divider
    logic [SBW-1:0] sb2;
    logic [SBW-1:0] r_sb_dly [0:DN-1];

    assign sb2 = {r2_n[0], r2_n[1], r2_n[2], r2_d[31], r2_zero};

    always_ff @(posedge i_clk) begin
        r_sb_dly[0] <= sb2;
        for (int j = 1; j < DN; j++) begin
            r_sb_dly[j] <= r_sb_dly[j-1];
        end
    end

    // Stage 3: d * N lane products
    logic signed [W+31:0] r3_pd [0:2];
    logic signed [W-1:0]  r3_l  [0:2];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r3_pd[i] <= r2_d * r2_n[i];
            r3_l[i]  <= r2_l[i];
        end
    end

    // Stage 4: tangential part d*N - L, saturated
    logic [TGW-1:0] r4_tang;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r4_tang[TGW-1-32*i -: 32] <=
                sat32(round_shr(t_wide'(r3_pd[i]), F) - t_wide'(r3_l[i]));
        end
    end

    // Hold the tangential part until the ratio is out
    logic [TGW-1:0] r_tg_dly [0:DN-3];

    always_ff @(posedge i_clk) begin
        r_tg_dly[0] <= r4_tang;
        for (int j = 1; j < DN - 2; j++) begin
            r_tg_dly[j] <= r_tg_dly[j-1];
        end
    end

    // Stage IA+1: ratio times tangential part
    t_s32                ratio;
    logic [TGW-1:0]      tang_a;
    logic signed [63:0]  r5_pa [0:2];
    logic [SBW-1:0]      r5_sb;

    assign ratio  = sat32($signed(t_wide'(div_quo)));
    assign tang_a = r_tg_dly[DN-3];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r5_pa[i] <= ratio * $signed(tang_a[TGW-1-32*i -: 32]);
        end
        r5_sb <= r_sb_dly[DN-1];
    end

    // Stage IA+2: S saturated
    t_s32           r6_s [0:2];
    logic [SBW-1:0] r6_sb;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r6_s[i] <= sat32(round_shr(t_wide'(r5_pa[i]), F));
        end
        r6_sb <= r5_sb;
    end

    // Stage IA+3: squares of S
    logic signed [63:0] r7_sq [0:2];
    t_s32               r7_s  [0:2];
    logic [SBW-1:0]     r7_sb;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r7_sq[i] <= r6_s[i] * r6_s[i];
            r7_s[i]  <= r6_s[i];
        end
        r7_sb <= r6_sb;
    end

    // Stage IS: S.S, reflection test and root operand
    t_wide s2_sum;
    t_wide s2_rem;

    assign s2_sum = round_shr(t_wide'(r7_sq[0]), F) + round_shr(t_wide'(r7_sq[1]), F)
                  + round_shr(t_wide'(r7_sq[2]), F);
    assign s2_rem = ONE_W - s2_sum;

    logic [2*RB-1:0] r8_rad;
    logic [SSW-1:0]  r8_ss;

    always_ff @(posedge i_clk) begin
        r8_rad <= (2*RB)'(s2_rem[F:0]) << F;
        r8_ss  <= {r7_s[0], r7_s[1], r7_s[2], (s2_sum >= ONE_W), r7_sb};
    end

    // Square root, stages IS+1 .. IS+RB
    logic [RB-1:0] root;

    rvu_sqrt #(
        .RB (RB)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_radicand (r8_rad),
        .o_root     (root)
    );

    logic [SSW-1:0] r_ss_dly [0:RB-1];

    always_ff @(posedge i_clk) begin
        r_ss_dly[0] <= r8_ss;
        for (int j = 1; j < RB; j++) begin
            r_ss_dly[j] <= r_ss_dly[j-1];
        end
    end

    // Stage IS+RB+1: signed root times N
    logic [SSW-1:0]        ss_b;
    logic signed [RB:0]    root_s;
    logic signed [RB:0]    c_val;
    logic signed [W+RB:0]  r9_nc [0:2];
    t_s32                  r9_s  [0:2];
    logic                  r9_tir;
    logic                  r9_zero;

    assign ss_b   = r_ss_dly[RB-1];
    assign root_s = $signed({1'b0, root});
    assign c_val  = ss_b[1] ? -root_s : root_s;

    always_ff @(posedge i_clk) begin
        r9_nc[0] <= $signed(ss_b[3*W+1 -: W]) * c_val;
        r9_nc[1] <= $signed(ss_b[2*W+1 -: W]) * c_val;
        r9_nc[2] <= $signed(ss_b[W+1 -: W]) * c_val;
        for (int i = 0; i < 3; i++) begin
            r9_s[i] <= $signed(ss_b[SSW-1-32*i -: 32]);
        end
        r9_tir  <= ss_b[SBW];
        r9_zero <= ss_b[0];
    end

    // Output stage: T = S - c*N clamped, outcome select
    t_wide               t_raw [0:2];
    logic signed [W-1:0] t_sat [0:2];
    logic        [1:0]   n_outcome;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t_raw[i] = t_wide'(r9_s[i]) - round_shr(t_wide'(r9_nc[i]), F);
            if (t_raw[i] > SMAX_W) begin
                t_sat[i] = SMAX_W[W-1:0];
            end else if (t_raw[i] < SMIN_W) begin
                t_sat[i] = SMIN_W[W-1:0];
            end else begin
                t_sat[i] = t_raw[i][W-1:0];
            end
        end
        if (r9_zero) begin
            n_outcome = OUT_ZERO_INDEX;
        end else if (r9_tir) begin
            n_outcome = OUT_TIR;
        end else begin
            n_outcome = OUT_REFRACT;
        end
    end

    always_ff @(posedge i_clk) begin
        o_outcome <= n_outcome;
        if (n_outcome == OUT_REFRACT) begin
            o_refracted_x <= t_sat[0];
            o_refracted_y <= t_sat[1];
            o_refracted_z <= t_sat[2];
        end else begin
            o_refracted_x <= '0;
            o_refracted_y <= '0;
            o_refracted_z <= '0;
        end
    end

    assign o_valid = r_vld[OI];

`ifndef SYNTH
    a_flag_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_outcome != OUT_REFRACT) |->
            (o_refracted_x == '0) && (o_refracted_y == '0) && (o_refracted_z == '0))
        else $error("flagged result carries a nonzero vector");

    a_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(accept && ((i_index_front == '0) || (i_index_back == '0)), LAT)
            |-> (o_outcome == OUT_ZERO_INDEX))
        else $error("zero index not flagged at the matching result");

    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LAT))
        else $error("result strobe without a matching transfer");
`endif

endmodule

[test/tb_refraction_vector_unit.sv]
`timescale 1ns / 1ps
module tb_refraction_vector_unit;
    import rvu_pkg::*;

    localparam int W = 16;
    localparam int F = 14;
    localparam int PIPE_DEPTH = W + 2 * F + 11;
    localparam longint ONE_Q = longint'(1) << F;

    typedef logic signed [W-1:0] comp_t;

    typedef struct packed {
        comp_t      tx;
        comp_t      ty;
        comp_t      tz;
        logic [1:0] outcome;
    } refraction_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    comp_t         i_incident_x = '0;
    comp_t         i_incident_y = '0;
    comp_t         i_incident_z = '0;
    comp_t         i_normal_x = '0;
    comp_t         i_normal_y = '0;
    comp_t         i_normal_z = '0;
    logic [W-1:0]  i_index_front = '0;
    logic [W-1:0]  i_index_back = '0;
    logic          o_valid;
    comp_t         o_refracted_x;
    comp_t         o_refracted_y;
    comp_t         o_refracted_z;
    logic [1:0]    o_outcome;

    refraction_t pending_rays[$];
    int          error_count = 0;
    int          sender_idle_pct = 0;

    refraction_vector_unit u_top (.*);

    // Clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop
    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Fixed-point product, rounded half up
    function automatic longint qmul(longint a, longint b);
        return (a * b + (longint'(1) << (F - 1))) >>> F;
    endfunction

    // Snell refraction in vector form, bit exact
    function automatic refraction_t predict_refraction(comp_t lx, comp_t ly, comp_t lz,
                                                       comp_t nx, comp_t ny, comp_t nz,
                                                       logic [W-1:0] nf, logic [W-1:0] nb);
        refraction_t res;
        longint l[3];
        longint n[3];
        longint s[3];
        longint d, ratio, s2, c, t;
        longint unsigned num, den, rad, root, bitv;
        res = '0;
        l[0] = lx; l[1] = ly; l[2] = lz;
        n[0] = nx; n[1] = ny; n[2] = nz;
        if (nf == 0 || nb == 0) begin
            res.outcome = OUT_ZERO_INDEX;
            return res;
        end
        d = sat_s32(qmul(n[0], l[0]) + qmul(n[1], l[1]) + qmul(n[2], l[2]));
        if (d > 0) begin
            num = nf; den = nb;
        end else begin
            num = nb; den = nf;
        end
        ratio = sat_s32(longint'(((num << F) + (den >> 1)) / den));
        s2 = 0;
        for (int i = 0; i < 3; i++) begin
            s[i] = sat_s32(qmul(ratio, sat_s32(qmul(d, n[i]) - l[i])));
            s2 += qmul(s[i], s[i]);
        end
        if (s2 >= ONE_Q) begin
            res.outcome = OUT_TIR;
            return res;
        end
        // integer square root, truncated
        rad = longint'(ONE_Q - s2) << F;
        root = 0;
        bitv = longint'(1) << 62;
        while (bitv > rad) bitv >>= 2;
        while (bitv != 0) begin
            if (rad >= root + bitv) begin
                rad -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        c = (d < 0) ? -longint'(root) : longint'(root);
        for (int i = 0; i < 3; i++) begin
            t = s[i] - qmul(n[i], c);
            if (t > 32767) t = 32767;
            if (t < -32768) t = -32768;
            if (i == 0) res.tx = comp_t'(t);
            else if (i == 1) res.ty = comp_t'(t);
            else res.tz = comp_t'(t);
        end
        res.outcome = OUT_REFRACT;
        return res;
    endfunction

    // Check every result transfer against the oldest prediction
    always @(posedge i_clk) begin
        refraction_t want;
        if (i_rst_n && o_valid) begin
            if (pending_rays.size() == 0) begin
                $display("%0t: unexpected result %h %h %h outcome %0d", $time,
                         o_refracted_x, o_refracted_y, o_refracted_z, o_outcome);
                error_count++;
            end else begin
                want = pending_rays.pop_front();
                if (o_refracted_x !== want.tx) begin
                    $display("%0t: x expected %h actual %h", $time, want.tx, o_refracted_x);
                    error_count++;
                end
                if (o_refracted_y !== want.ty) begin
                    $display("%0t: y expected %h actual %h", $time, want.ty, o_refracted_y);
                    error_count++;
                end
                if (o_refracted_z !== want.tz) begin
                    $display("%0t: z expected %h actual %h", $time, want.tz, o_refracted_z);
                    error_count++;
                end
                if (o_outcome !== want.outcome) begin
                    $display("%0t: outcome expected %0d actual %0d", $time,
                             want.outcome, o_outcome);
                    error_count++;
                end
            end
        end
    end

    // Start one ray, with random idle cycles first, and record its prediction
    task automatic send_ray(comp_t lx, comp_t ly, comp_t lz, comp_t nx, comp_t ny, comp_t nz,
                            logic [W-1:0] nf, logic [W-1:0] nb);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_incident_x <= lx; i_incident_y <= ly; i_incident_z <= lz;
        i_normal_x <= nx; i_normal_y <= ny; i_normal_z <= nz;
        i_index_front <= nf; i_index_back <= nb;
        do @(posedge i_clk); while (busy);
        pending_rays.push_back(predict_refraction(lx, ly, lz, nx, ny, nz, nf, nb));
    endtask

    // Hold off until the pipeline is empty
    task automatic drain_pipeline();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_rays.size() != 0 && guard < 10 * PIPE_DEPTH) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
    endtask

    function automatic void unit_vector(output comp_t x, output comp_t y, output comp_t z);
        real a, b, c, m;
        a = real'(int'($urandom_range(2000)) - 1000);
        b = real'(int'($urandom_range(2000)) - 1000);
        c = real'(int'($urandom_range(2000)) - 1000);
        m = $sqrt(a * a + b * b + c * c);
        if (m < 1.0) begin
            a = 1.0; m = 1.0;
        end
        x = comp_t'($rtoi(a / m * 16384.0));
        y = comp_t'($rtoi(b / m * 16384.0));
        z = comp_t'($rtoi(c / m * 16384.0));
    endfunction

    // Extremes and the special cases
    task automatic test_directed();
        sender_idle_pct = 0;
        send_ray(0, 0, 16384, 0, 0, 16384, 0, 16384);
        send_ray(0, 0, 16384, 0, 0, 16384, 16384, 0);
        send_ray(0, 0, 16384, 0, 0, 16384, 0, 0);
        send_ray(0, 0, 16384, 0, 0, 16384, 16384, 24576);
        send_ray(0, 0, -16384, 0, 0, 16384, 24576, 16384);
        send_ray(16384, 0, 0, 0, 0, 16384, 16384, 24576);
        send_ray(16384, 0, 0, 0, 0, 16384, 24576, 16384);
        send_ray(11585, 0, 11585, 0, 0, 16384, 16384, 24576);
        send_ray(11585, 0, -11585, 0, 0, 16384, 16384, 24576);
        send_ray(11585, 0, -11585, 0, 0, 16384, 24576, 16384);
        send_ray(14189, 0, 8192, 0, 0, 16384, 24576, 16384);
        send_ray(-32768, -32768, -32768, -32768, -32768, -32768, 65535, 65535);
        send_ray(32767, 32767, 32767, 32767, 32767, 32767, 65535, 1);
        send_ray(32767, 32767, 32767, -32768, -32768, -32768, 1, 65535);
        send_ray(-32768, 32767, 0, 32767, -32768, 0, 65535, 1);
        send_ray(0, 0, 0, 0, 0, 0, 16384, 16384);
        send_ray(0, 0, 0, 32767, 0, 0, 1, 1);
        send_ray(0, 16384, 0, 0, 16384, 0, 65535, 65535);
        send_ray(9459, 9459, 9459, 0, 16384, 0, 1, 65535);
        send_ray(-9459, 9459, -9459, 0, 16384, 0, 65535, 16384);
        drain_pipeline();
    endtask

    // Mostly physical rays, some raw noise and some zero indices
    task automatic test_random_rays(int count, int idle_pct);
        comp_t lx, ly, lz, nx, ny, nz;
        logic [W-1:0] nf, nb;
        int pick;
        sender_idle_pct = idle_pct;
        for (int k = 0; k < count; k++) begin
            unit_vector(lx, ly, lz);
            unit_vector(nx, ny, nz);
            nf = W'($urandom_range(40960, 16384));
            nb = W'($urandom_range(40960, 16384));
            pick = $urandom_range(99);
            if (pick < 15) begin
                lx = comp_t'($urandom); ly = comp_t'($urandom); lz = comp_t'($urandom);
                nx = comp_t'($urandom); ny = comp_t'($urandom); nz = comp_t'($urandom);
                nf = W'($urandom); nb = W'($urandom);
            end else if (pick < 18) begin
                if ($urandom_range(1)) nf = '0;
                else nb = '0;
            end
            send_ray(lx, ly, lz, nx, ny, nz, nf, nb);
            // stop the stream once for a full flush
            if (k == count / 2 && idle_pct == 13) drain_pipeline();
        end
        drain_pipeline();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_rays(480, 13);
        test_random_rays(480, 71);
        test_random_rays(480, 0);
        if (error_count == 0 && pending_rays.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
src/rvu_pkg.sv
src/rvu_div.sv
src/rvu_sqrt.sv
src/refraction_vector_unit.sv
test/tb_refraction_vector_unit.sv
